/* src/lvm_pkg.sv */
// Shared types and fixed constants of the look-at view matrix block.
// No dependencies; every other file of the block refers to it by scope.
`default_nettype none

package lvm_pkg;

  // Width of an input coordinate and of a translation entry.
  localparam int COORD_W = 32;

  // Width of a rotation entry.
  localparam int AXIS_W = 16;

  // The largest scaled magnitude in lvm_norm lies in [2^(NORM_BITS-1), 2^NORM_BITS).
  localparam int NORM_BITS = 30;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [AXIS_W-1:0]  axis_t;

  // Status that travels next to a normalized vector.
  typedef struct packed {
    logic valid;
    logic ok;
  } lvm_flag_t;

endpackage

`default_nettype wire

/* src/lvm_if.sv */
// Valid/ready channel interfaces for the vector sets and the matrix results.
// Depends on lvm_pkg for the coordinate and axis types.
`default_nettype none

interface lvm_in_if;
  logic valid;
  logic ready;
  lvm_pkg::coord_t eye_x;
  lvm_pkg::coord_t eye_y;
  lvm_pkg::coord_t eye_z;
  lvm_pkg::coord_t target_x;
  lvm_pkg::coord_t target_y;
  lvm_pkg::coord_t target_z;
  lvm_pkg::coord_t upvec_x;
  lvm_pkg::coord_t upvec_y;
  lvm_pkg::coord_t upvec_z;

  modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  upvec_x, upvec_y, upvec_z, input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                upvec_x, upvec_y, upvec_z, output ready);
endinterface

interface lvm_out_if;
  logic valid;
  logic ready;
  lvm_pkg::axis_t  right_x;
  lvm_pkg::axis_t  right_y;
  lvm_pkg::axis_t  right_z;
  lvm_pkg::axis_t  trueup_x;
  lvm_pkg::axis_t  trueup_y;
  lvm_pkg::axis_t  trueup_z;
  lvm_pkg::axis_t  back_x;
  lvm_pkg::axis_t  back_y;
  lvm_pkg::axis_t  back_z;
  lvm_pkg::coord_t shift_right;
  lvm_pkg::coord_t shift_up;
  lvm_pkg::coord_t shift_back;

  modport source (output valid, right_x, right_y, right_z, trueup_x, trueup_y, trueup_z,
                  back_x, back_y, back_z, shift_right, shift_up, shift_back,
                  input ready);
  modport sink (input valid, right_x, right_y, right_z, trueup_x, trueup_y, trueup_z,
                back_x, back_y, back_z, shift_right, shift_up, shift_back,
                output ready);
endinterface

`default_nettype wire

/* src/look_at_view_matrix.sv */
// Top level of the right-handed look-at view matrix pipeline.
// Depends on lvm_pkg, the channel interfaces in lvm_if and lvm_norm.
//
//   channel   dir   payload                                       handshake
//   in_ch     in    eye, target, up hint (9 x Q16.16)             valid/ready
//   out_ch    out   9 rotation Q1.14, 3 translation Q16.16        valid/ready
//
// One transaction enters per clock while the pipeline is not held; most of its
// stages sit in the two normalizers (a 31-stage square root, a one-bit-per-stage divider).
// Reset clears only the valid bits of the stages.
// The whole pipeline holds while the output register is full and not taken;
// in_ch.ready follows that condition, so a stall loses and repeats nothing.
`default_nettype none

module look_at_view_matrix #(
  parameter int POS_FRAC_BITS  = 16,
  parameter int AXIS_FRAC_BITS = 14
) (
  input  logic   clk,
  input  logic   rst_n,
  lvm_in_if.sink    in_ch,
  lvm_out_if.source out_ch
);

  localparam int F     = AXIS_FRAC_BITS;
  localparam int CWD   = lvm_pkg::COORD_W;
  localparam int DW    = CWD + 1;
  localparam int UW    = F + 2;
  localparam int PRW   = CWD + UW;
  localparam int CW    = PRW + 1;
  localparam int TPW   = 2 * UW;
  localparam int TDW   = TPW + 1;
  localparam int TW    = F + 3;
  localparam int EW    = TW + CWD;
  localparam int NDW   = EW + 3;
  localparam int SH    = F + 16 - POS_FRAC_BITS;
  localparam int SIDE1 = 6 * CWD;
  localparam int SIDE2 = 3 * CWD + 3 * UW + 1;

  localparam logic [TDW-1:0]        T_HALF = (TDW'(1) << F) >> 1;
  localparam logic [NDW-1:0]        P_HALF = (NDW'(1) << SH) >> 1;
  localparam logic signed [NDW-1:0] P_HI   = NDW'(2147483647);
  localparam logic signed [NDW-1:0] P_LO   = -P_HI - NDW'(1);

  function automatic lvm_pkg::axis_t sat16(input logic signed [47:0] v);
    lvm_pkg::axis_t r;
    if (v > 48'sd32767) r = 16'sh7fff;
    else if (v < -48'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  logic en;
  logic out_valid_r;

  // The pipeline advances whenever the output register can take a result.
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 0: capture the transaction and form eye minus target.
  logic                   s0_v_r;
  logic signed [DW-1:0]   s0_d_r [3];
  lvm_pkg::coord_t        s0_eye_r [3];
  lvm_pkg::coord_t        s0_up_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_d_r[0]   <= DW'(in_ch.eye_x) - DW'(in_ch.target_x);
      s0_d_r[1]   <= DW'(in_ch.eye_y) - DW'(in_ch.target_y);
      s0_d_r[2]   <= DW'(in_ch.eye_z) - DW'(in_ch.target_z);
      s0_eye_r[0] <= in_ch.eye_x;
      s0_eye_r[1] <= in_ch.eye_y;
      s0_eye_r[2] <= in_ch.eye_z;
      s0_up_r[0]  <= in_ch.upvec_x;
      s0_up_r[1]  <= in_ch.upvec_y;
      s0_up_r[2]  <= in_ch.upvec_z;
    end
  end

  // Direction normalizer; eye and up hint ride along.
  logic [SIDE1-1:0]     n1_side_in;
  logic [SIDE1-1:0]     n1_side;
  lvm_pkg::lvm_flag_t   n1_flag;
  logic signed [UW-1:0] n1_dir [3];
  lvm_pkg::coord_t      n1_eye [3];
  lvm_pkg::coord_t      n1_up [3];

  assign n1_side_in = {s0_eye_r[0], s0_eye_r[1], s0_eye_r[2],
                       s0_up_r[0], s0_up_r[1], s0_up_r[2]};

  lvm_norm #(.IW(DW), .F(F), .SIDE_W(SIDE1)) u_norm_dir (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s0_v_r),
    .in_vec   (s0_d_r),
    .in_side  (n1_side_in),
    .out_flag (n1_flag),
    .out_vec  (n1_dir),
    .out_side (n1_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n1_eye[i] = $signed(n1_side[SIDE1-1-CWD*i -: CWD]);
      n1_up[i]  = $signed(n1_side[SIDE1-1-CWD*(3+i) -: CWD]);
    end
  end

  // Stage X1: partial products of up cross direction.
  logic                  x1_v_r;
  logic signed [PRW-1:0] x1_p_r [6];
  lvm_pkg::coord_t       x1_eye_r [3];
  logic signed [UW-1:0]  x1_dir_r [3];
  logic                  x1_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_v_r <= 1'b0;
    end else if (en) begin
      x1_v_r <= n1_flag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_p_r[0] <= n1_up[1] * n1_dir[2];
      x1_p_r[1] <= n1_up[2] * n1_dir[1];
      x1_p_r[2] <= n1_up[2] * n1_dir[0];
      x1_p_r[3] <= n1_up[0] * n1_dir[2];
      x1_p_r[4] <= n1_up[0] * n1_dir[1];
      x1_p_r[5] <= n1_up[1] * n1_dir[0];
      x1_eye_r  <= n1_eye;
      x1_dir_r  <= n1_dir;
      x1_ok_r   <= n1_flag.ok;
    end
  end

  // Stage X2: cross product differences.
  logic                 x2_v_r;
  logic signed [CW-1:0] x2_c_r [3];
  lvm_pkg::coord_t      x2_eye_r [3];
  logic signed [UW-1:0] x2_dir_r [3];
  logic                 x2_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x2_v_r <= 1'b0;
    end else if (en) begin
      x2_v_r <= x1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        x2_c_r[i] <= CW'(x1_p_r[2*i]) - CW'(x1_p_r[2*i+1]);
      end
      x2_eye_r <= x1_eye_r;
      x2_dir_r <= x1_dir_r;
      x2_ok_r  <= x1_ok_r;
    end
  end

  // Right axis normalizer; eye, direction and the first status ride along.
  logic [SIDE2-1:0]     n2_side_in;
  logic [SIDE2-1:0]     n2_side;
  lvm_pkg::lvm_flag_t   n2_flag;
  logic signed [UW-1:0] n2_right [3];
  lvm_pkg::coord_t      n2_eye [3];
  logic signed [UW-1:0] n2_dir [3];

  assign n2_side_in = {x2_eye_r[0], x2_eye_r[1], x2_eye_r[2],
                       x2_dir_r[0], x2_dir_r[1], x2_dir_r[2], x2_ok_r};

  lvm_norm #(.IW(CW), .F(F), .SIDE_W(SIDE2)) u_norm_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (x2_v_r),
    .in_vec   (x2_c_r),
    .in_side  (n2_side_in),
    .out_flag (n2_flag),
    .out_vec  (n2_right),
    .out_side (n2_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n2_eye[i] = $signed(n2_side[SIDE2-1-CWD*i -: CWD]);
      n2_dir[i] = $signed(n2_side[3*UW-UW*i -: UW]);
    end
  end

  // Stage T1: partial products of direction cross right.
  logic                  t1_v_r;
  logic signed [TPW-1:0] t1_p_r [6];
  lvm_pkg::coord_t       t1_eye_r [3];
  logic signed [UW-1:0]  t1_dir_r [3];
  logic signed [UW-1:0]  t1_right_r [3];
  logic                  t1_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
    end else if (en) begin
      t1_v_r <= n2_flag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_p_r[0]  <= n2_dir[1] * n2_right[2];
      t1_p_r[1]  <= n2_dir[2] * n2_right[1];
      t1_p_r[2]  <= n2_dir[2] * n2_right[0];
      t1_p_r[3]  <= n2_dir[0] * n2_right[2];
      t1_p_r[4]  <= n2_dir[0] * n2_right[1];
      t1_p_r[5]  <= n2_dir[1] * n2_right[0];
      t1_eye_r   <= n2_eye;
      t1_dir_r   <= n2_dir;
      t1_right_r <= n2_right;
      t1_ok_r    <= n2_side[0] && n2_flag.ok;
    end
  end

  // Stage T2: differences, then rounding half away from zero back to F bits.
  logic signed [TDW-1:0] t_diff [3];
  logic [TDW-1:0]        t_mag [3];
  logic [TDW-1:0]        t_rnd [3];
  logic signed [TW-1:0]  t_val [3];
  logic                  t2_v_r;
  logic signed [TW-1:0]  t2_t_r [3];
  lvm_pkg::coord_t       t2_eye_r [3];
  logic signed [UW-1:0]  t2_dir_r [3];
  logic signed [UW-1:0]  t2_right_r [3];
  logic                  t2_ok_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_diff[i] = TDW'(t1_p_r[2*i]) - TDW'(t1_p_r[2*i+1]);
      t_mag[i]  = t_diff[i][TDW-1] ? TDW'(-t_diff[i]) : TDW'(t_diff[i]);
      t_rnd[i]  = (t_mag[i] + T_HALF) >> F;
      t_val[i]  = t_diff[i][TDW-1] ? -$signed(t_rnd[i][TW-1:0]) : $signed(t_rnd[i][TW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_v_r <= 1'b0;
    end else if (en) begin
      t2_v_r <= t1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_t_r     <= t_val;
      t2_eye_r   <= t1_eye_r;
      t2_dir_r   <= t1_dir_r;
      t2_right_r <= t1_right_r;
      t2_ok_r    <= t1_ok_r;
    end
  end

  // Stage P1: products of each axis with the eye; rotation entries saturate.
  logic                 p1_v_r;
  logic signed [EW-1:0] p1_pr_r [3][3];
  lvm_pkg::axis_t       p1_rot_r [9];
  logic                 p1_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= t2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_pr_r[0][i]  <= t2_right_r[i] * t2_eye_r[i];
        p1_pr_r[1][i]  <= t2_t_r[i] * t2_eye_r[i];
        p1_pr_r[2][i]  <= t2_dir_r[i] * t2_eye_r[i];
        p1_rot_r[i]    <= sat16(48'(t2_right_r[i]));
        p1_rot_r[3+i]  <= sat16(48'(t2_t_r[i]));
        p1_rot_r[6+i]  <= sat16(48'(t2_dir_r[i]));
      end
      p1_ok_r <= t2_ok_r;
    end
  end

  // Stage P2: negated dot products.
  logic                  p2_v_r;
  logic signed [NDW-1:0] p2_nd_r [3];
  lvm_pkg::axis_t        p2_rot_r [9];
  logic                  p2_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (en) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        p2_nd_r[a] <= -(NDW'(p1_pr_r[a][0]) + NDW'(p1_pr_r[a][1]) + NDW'(p1_pr_r[a][2]));
      end
      p2_rot_r <= p1_rot_r;
      p2_ok_r  <= p1_ok_r;
    end
  end

  // Output stage: round the translations to the position format and saturate.
  logic [NDW-1:0]        p_mag [3];
  logic [NDW-1:0]        p_rnd [3];
  logic signed [NDW-1:0] p_val [3];
  lvm_pkg::coord_t       p_sat [3];
  lvm_pkg::axis_t        o_rot_r [9];
  lvm_pkg::coord_t       o_tr_r [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      p_mag[a] = p2_nd_r[a][NDW-1] ? NDW'(-p2_nd_r[a]) : NDW'(p2_nd_r[a]);
      p_rnd[a] = (p_mag[a] + P_HALF) >> SH;
      p_val[a] = p2_nd_r[a][NDW-1] ? -$signed(p_rnd[a]) : $signed(p_rnd[a]);
      if (p_val[a] > P_HI) p_sat[a] = P_HI[CWD-1:0];
      else if (p_val[a] < P_LO) p_sat[a] = P_LO[CWD-1:0];
      else p_sat[a] = p_val[a][CWD-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p2_v_r;
    end
  end

  // A degenerate input clears every field of the result.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        o_rot_r[i] <= p2_ok_r ? p2_rot_r[i] : '0;
      end
      for (int a = 0; a < 3; a++) begin
        o_tr_r[a] <= p2_ok_r ? p_sat[a] : '0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.right_x     = o_rot_r[0];
  assign out_ch.right_y     = o_rot_r[1];
  assign out_ch.right_z     = o_rot_r[2];
  assign out_ch.trueup_x    = o_rot_r[3];
  assign out_ch.trueup_y    = o_rot_r[4];
  assign out_ch.trueup_z    = o_rot_r[5];
  assign out_ch.back_x      = o_rot_r[6];
  assign out_ch.back_y      = o_rot_r[7];
  assign out_ch.back_z      = o_rot_r[8];
  assign out_ch.shift_right = o_tr_r[0];
  assign out_ch.shift_up    = o_tr_r[1];
  assign out_ch.shift_back  = o_tr_r[2];

endmodule

`default_nettype wire

/* src/lvm_norm.sv */
// Pipelined 3-vector normalizer: scale, sum of squares, bit-per-stage square
// root and bit-per-stage restoring division. Depends on lvm_pkg.
`default_nettype none

module lvm_norm #(
  parameter int IW     = 33,
  parameter int F      = 14,
  parameter int SIDE_W = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [IW-1:0]      in_vec [3],
  input  logic [SIDE_W-1:0]         in_side,
  output lvm_pkg::lvm_flag_t        out_flag,
  output logic signed [F+1:0]       out_vec [3],
  output logic [SIDE_W-1:0]         out_side
);

  localparam int MB     = lvm_pkg::NORM_BITS;
  localparam int PW     = $clog2(IW + 1);
  localparam int SUM_W  = 2 * MB + 2;
  localparam int XW     = SUM_W + 2;
  localparam int STEPS  = MB + 1;
  localparam int RW     = MB + 1;
  localparam int NW     = MB + F + 1;
  localparam int QW     = F + 1;
  localparam int DSTEPS = F + 1;

  // Stage A: magnitudes, signs and the largest magnitude.
  logic [IW-1:0]     mag_in [3];
  logic [IW-1:0]     max01;
  logic [IW-1:0]     max_in;
  logic              a_v_r;
  logic [IW-1:0]     a_mag_r [3];
  logic [2:0]        a_neg_r;
  logic [IW-1:0]     a_max_r;
  logic [SIDE_W-1:0] a_side_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = in_vec[i][IW-1] ? IW'(-in_vec[i]) : IW'(in_vec[i]);
    end
    max01  = (mag_in[0] > mag_in[1]) ? mag_in[0] : mag_in[1];
    max_in = (max01 > mag_in[2]) ? max01 : mag_in[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_mag_r[i] <= mag_in[i];
        a_neg_r[i] <= in_vec[i][IW-1];
      end
      a_max_r  <= max_in;
      a_side_r <= in_side;
    end
  end

  // Stage B: position of the leading one of the largest magnitude.
  logic [PW-1:0]     sh_a;
  logic              b_v_r;
  logic [IW-1:0]     b_mag_r [3];
  logic [2:0]        b_neg_r;
  logic [PW-1:0]     b_sh_r;
  logic              b_ok_r;
  logic [SIDE_W-1:0] b_side_r;

  always_comb begin
    sh_a = '0;
    for (int i = 0; i < IW; i++) begin
      if (a_max_r[i]) sh_a = PW'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_mag_r  <= a_mag_r;
      b_neg_r  <= a_neg_r;
      b_sh_r   <= sh_a;
      b_ok_r   <= |a_max_r;
      b_side_r <= a_side_r;
    end
  end

  // Stage C: common shift that puts the largest magnitude's top bit at MB-1.
  logic [IW+MB-1:0]  wide [3];
  logic              c_v_r;
  logic [MB-1:0]     c_mag_r [3];
  logic [2:0]        c_neg_r;
  logic              c_ok_r;
  logic [SIDE_W-1:0] c_side_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = {b_mag_r[i], {MB{1'b0}}} >> b_sh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c_mag_r[i] <= wide[i][MB-1:0];
      end
      c_neg_r  <= b_neg_r;
      c_ok_r   <= b_ok_r;
      c_side_r <= b_side_r;
    end
  end

  // Stage D: squares of the scaled magnitudes.
  logic              d_v_r;
  logic [2*MB-1:0]   d_sq_r [3];
  logic [MB-1:0]     d_mag_r [3];
  logic [2:0]        d_neg_r;
  logic              d_ok_r;
  logic [SIDE_W-1:0] d_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en) begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_sq_r[i] <= c_mag_r[i] * c_mag_r[i];
      end
      d_mag_r  <= c_mag_r;
      d_neg_r  <= c_neg_r;
      d_ok_r   <= c_ok_r;
      d_side_r <= c_side_r;
    end
  end

  // Square root pipeline; entry 0 holds the sum of squares.
  logic              sq_v_r    [STEPS+1];
  logic [XW-1:0]     sq_x_r    [STEPS+1];
  logic [XW-1:0]     sq_res_r  [STEPS+1];
  logic [MB-1:0]     sq_mag_r  [STEPS+1][3];
  logic [2:0]        sq_neg_r  [STEPS+1];
  logic              sq_ok_r   [STEPS+1];
  logic [SIDE_W-1:0] sq_side_r [STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x_r[0]    <= XW'(d_sq_r[0]) + XW'(d_sq_r[1]) + XW'(d_sq_r[2]);
      sq_res_r[0]  <= '0;
      sq_mag_r[0]  <= d_mag_r;
      sq_neg_r[0]  <= d_neg_r;
      sq_ok_r[0]   <= d_ok_r;
      sq_side_r[0] <= d_side_r;
    end
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_sqrt
    localparam int BITPOS = 2 * (STEPS - 1 - j);
    logic [XW-1:0] bit_w;
    logic [XW-1:0] trial;

    assign bit_w = XW'(1) << BITPOS;
    assign trial = sq_res_r[j] + bit_w;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[j+1] <= sq_v_r[j];
      end
    end

    // One result bit per stage.
    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_x_r[j] >= trial) begin
          sq_x_r[j+1]   <= sq_x_r[j] - trial;
          sq_res_r[j+1] <= (sq_res_r[j] >> 1) + bit_w;
        end else begin
          sq_x_r[j+1]   <= sq_x_r[j];
          sq_res_r[j+1] <= sq_res_r[j] >> 1;
        end
        sq_mag_r[j+1]  <= sq_mag_r[j];
        sq_neg_r[j+1]  <= sq_neg_r[j];
        sq_ok_r[j+1]   <= sq_ok_r[j];
        sq_side_r[j+1] <= sq_side_r[j];
      end
    end
  end

  // Division pipeline; entry 0 holds the rounded numerators and the root.
  logic [RW-1:0]     root;
  logic              dv_v_r    [DSTEPS+1];
  logic [NW-1:0]     dv_rem_r  [DSTEPS+1][3];
  logic [QW-1:0]     dv_q_r    [DSTEPS+1][3];
  logic [RW-1:0]     dv_div_r  [DSTEPS+1];
  logic [2:0]        dv_neg_r  [DSTEPS+1];
  logic              dv_ok_r   [DSTEPS+1];
  logic [SIDE_W-1:0] dv_side_r [DSTEPS+1];

  assign root = sq_res_r[STEPS][RW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= NW'({sq_mag_r[STEPS][i], {F{1'b0}}}) + NW'(root >> 1);
        dv_q_r[0][i]   <= '0;
      end
      dv_div_r[0]  <= root;
      dv_neg_r[0]  <= sq_neg_r[STEPS];
      dv_ok_r[0]   <= sq_ok_r[STEPS];
      dv_side_r[0] <= sq_side_r[STEPS];
    end
  end

  for (genvar j = 0; j < DSTEPS; j++) begin : g_div
    localparam int K = F - j;
    logic [NW-1:0] dsh;

    assign dsh = NW'(dv_div_r[j]) << K;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    // One quotient bit per stage for all three components.
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (dv_rem_r[j][i] >= dsh) begin
            dv_rem_r[j+1][i] <= dv_rem_r[j][i] - dsh;
            dv_q_r[j+1][i]   <= {dv_q_r[j][i][QW-2:0], 1'b1};
          end else begin
            dv_rem_r[j+1][i] <= dv_rem_r[j][i];
            dv_q_r[j+1][i]   <= {dv_q_r[j][i][QW-2:0], 1'b0};
          end
        end
        dv_div_r[j+1]  <= dv_div_r[j];
        dv_neg_r[j+1]  <= dv_neg_r[j];
        dv_ok_r[j+1]   <= dv_ok_r[j];
        dv_side_r[j+1] <= dv_side_r[j];
      end
    end
  end

  // Output stage: restore the signs.
  logic signed [F+1:0] qs [3];
  logic                o_v_r;
  logic                o_ok_r;
  logic signed [F+1:0] o_vec_r [3];
  logic [SIDE_W-1:0]   o_side_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = $signed({1'b0, dv_q_r[DSTEPS][i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (en) begin
      o_v_r <= dv_v_r[DSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        o_vec_r[i] <= dv_neg_r[DSTEPS][i] ? -qs[i] : qs[i];
      end
      o_ok_r   <= dv_ok_r[DSTEPS];
      o_side_r <= dv_side_r[DSTEPS];
    end
  end

  assign out_flag.valid = o_v_r;
  assign out_flag.ok    = o_ok_r;
  assign out_vec        = o_vec_r;
  assign out_side       = o_side_r;

endmodule

`default_nettype wire

/* test/lvm_tb_if.sv */
// Record types for the look-at view matrix testbench.
// Depends on lvm_pkg; the block's own interfaces live in src/lvm_if.sv.
`timescale 1ns / 1ps

// The testbench uses the block's lvm_in_if and lvm_out_if directly.
// This file keeps the vector-set record that the scoreboard and driver share.
package lvm_tb_pkg;

  typedef struct {
    lvm_pkg::coord_t eye_x, eye_y, eye_z;
    lvm_pkg::coord_t target_x, target_y, target_z;
    lvm_pkg::coord_t upvec_x, upvec_y, upvec_z;
  } vec_set_t;

  typedef struct {
    lvm_pkg::axis_t  right_x, right_y, right_z;
    lvm_pkg::axis_t  trueup_x, trueup_y, trueup_z;
    lvm_pkg::axis_t  back_x, back_y, back_z;
    lvm_pkg::coord_t shift_right, shift_up, shift_back;
  } view_mat_t;
endpackage

/* test/look_at_view_matrix_tb.sv */
// Testbench for look_at_view_matrix: drives random and corner vector sets and
// checks each matrix against a fixed-point predictor kept in a scoreboard class.
// Depends on lvm_pkg, lvm_if (src) and lvm_tb_pkg (test/lvm_tb_if.sv).
`timescale 1ns / 1ps

module look_at_view_matrix_tb;

  localparam int POS_FB  = 16;
  localparam int AXIS_FB = 14;
  localparam int LATENCY = 2 * AXIS_FB + 85;
  localparam int N_RANDOM = 750;

  // Scoreboard: predicts the view matrix and holds the pending expectations.
  class view_matrix_board;
    lvm_tb_pkg::view_mat_t pending_mats[$];
    int        mismatches;

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function longint round_away(longint v, int s);
      longint m;
      m = mag(v);
      if (s > 0) m = (m + (longint'(1) << (s - 1))) >>> s;
      return (v < 0) ? -m : m;
    endfunction

    function longint int_sqrt(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return longint'(res);
    endfunction

    // Unit vector at AXIS_FB fraction bits; returns 0 for a zero vector.
    function bit unit_vec(input longint v[3], output longint u[3]);
      longint unsigned m3[3], mx, sum, r, q;
      int rs, ls;
      mx = 0;
      sum = 0;
      rs = 0;
      ls = 0;
      for (int i = 0; i < 3; i++) begin
        m3[i] = mag(v[i]);
        if (m3[i] > mx) mx = m3[i];
      end
      if (mx == 0) return 0;
      while ((mx >> rs) >= (64'd1 << 30)) rs++;
      if (rs == 0) while ((mx << ls) < (64'd1 << 29)) ls++;
      for (int i = 0; i < 3; i++) begin
        m3[i] = (rs != 0) ? (m3[i] >> rs) : (m3[i] << ls);
        sum += m3[i] * m3[i];
      end
      r = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q = ((m3[i] << AXIS_FB) + (r >> 1)) / r;
        u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
      return 1;
    endfunction

    function void cross3(input longint a[3], input longint b[3], output longint c[3]);
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function lvm_pkg::axis_t sat16(longint v);
      if (v < -32768) return 16'sh8000;
      if (v > 32767) return 16'sh7fff;
      return lvm_pkg::axis_t'(v);
    endfunction

    function lvm_pkg::coord_t shift_of(input longint ax[3], input longint eye[3]);
      longint t;
      t = round_away(-(ax[0] * eye[0] + ax[1] * eye[1] + ax[2] * eye[2]),
                     AXIS_FB + 16 - POS_FB);
      if (t < -64'sd2147483648) return 32'h8000_0000;
      if (t > 64'sd2147483647) return 32'h7fff_ffff;
      return lvm_pkg::coord_t'(t);
    endfunction

    // Notes one accepted vector set and queues its predicted matrix.
    function void note_vec_set(lvm_tb_pkg::vec_set_t s);
      longint eye[3], d[3], up[3], dir[3], c[3], rt[3], tu[3];
      lvm_tb_pkg::view_mat_t e;
      bit ok;
      eye = '{s.eye_x, s.eye_y, s.eye_z};
      d = '{longint'(s.eye_x) - s.target_x, longint'(s.eye_y) - s.target_y,
            longint'(s.eye_z) - s.target_z};
      up = '{s.upvec_x, s.upvec_y, s.upvec_z};
      e = '{default: 0};
      ok = unit_vec(d, dir);
      if (ok) begin
        cross3(up, dir, c);
        ok = unit_vec(c, rt);
      end
      if (ok) begin
        cross3(dir, rt, tu);
        for (int i = 0; i < 3; i++) tu[i] = round_away(tu[i], AXIS_FB);
        e.right_x = sat16(rt[0]);  e.right_y = sat16(rt[1]);  e.right_z = sat16(rt[2]);
        e.trueup_x = sat16(tu[0]); e.trueup_y = sat16(tu[1]); e.trueup_z = sat16(tu[2]);
        e.back_x = sat16(dir[0]);  e.back_y = sat16(dir[1]);  e.back_z = sat16(dir[2]);
        e.shift_right = shift_of(rt, eye);
        e.shift_up = shift_of(tu, eye);
        e.shift_back = shift_of(dir, eye);
      end
      pending_mats.push_back(e);
    endfunction

    function void report(string f, longint exp_v, longint act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d, got %0d", f, exp_v, act_v);
    endfunction

    // Compares one received matrix with the oldest expectation.
    function void check_matrix(lvm_tb_pkg::view_mat_t a);
      lvm_tb_pkg::view_mat_t e;
      if (pending_mats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: result with no vector set pending");
        return;
      end
      e = pending_mats.pop_front();
      if (a.right_x !== e.right_x) report("right_x", e.right_x, a.right_x);
      if (a.right_y !== e.right_y) report("right_y", e.right_y, a.right_y);
      if (a.right_z !== e.right_z) report("right_z", e.right_z, a.right_z);
      if (a.trueup_x !== e.trueup_x) report("trueup_x", e.trueup_x, a.trueup_x);
      if (a.trueup_y !== e.trueup_y) report("trueup_y", e.trueup_y, a.trueup_y);
      if (a.trueup_z !== e.trueup_z) report("trueup_z", e.trueup_z, a.trueup_z);
      if (a.back_x !== e.back_x) report("back_x", e.back_x, a.back_x);
      if (a.back_y !== e.back_y) report("back_y", e.back_y, a.back_y);
      if (a.back_z !== e.back_z) report("back_z", e.back_z, a.back_z);
      if (a.shift_right !== e.shift_right)
        report("shift_right", e.shift_right, a.shift_right);
      if (a.shift_up !== e.shift_up) report("shift_up", e.shift_up, a.shift_up);
      if (a.shift_back !== e.shift_back) report("shift_back", e.shift_back, a.shift_back);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lvm_in_if  in_ch ();
  lvm_out_if out_ch ();

  view_matrix_board board = new();
  bit stim_done = 1'b0;

  look_at_view_matrix #(
    .POS_FRAC_BITS (POS_FB),
    .AXIS_FRAC_BITS(AXIS_FB)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length: mostly short, sometimes long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Random coordinate: full range, small values, or the extremes.
  function automatic lvm_pkg::coord_t rand_coord();
    case ($urandom_range(0, 5))
      0, 1: return lvm_pkg::coord_t'($urandom());
      2: return lvm_pkg::coord_t'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
      3: return lvm_pkg::coord_t'($signed($urandom_range(0, 200)) - 100);
      4: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return lvm_pkg::coord_t'($signed($urandom_range(0, 2 * 65536 * 1000))
                                        - 65536000);
    endcase
  endfunction

  function automatic lvm_tb_pkg::vec_set_t rand_set();
    lvm_tb_pkg::vec_set_t s;
    s.eye_x = rand_coord(); s.eye_y = rand_coord(); s.eye_z = rand_coord();
    s.target_x = rand_coord(); s.target_y = rand_coord(); s.target_z = rand_coord();
    s.upvec_x = rand_coord(); s.upvec_y = rand_coord(); s.upvec_z = rand_coord();
    case ($urandom_range(0, 19))
      0: begin
        // Eye on the target.
        s.target_x = s.eye_x; s.target_y = s.eye_y; s.target_z = s.eye_z;
      end
      1: begin
        // Up hint along the axis of view, scaled by a small factor.
        s.target_x = s.eye_x - 3; s.target_y = s.eye_y; s.target_z = s.eye_z + 5;
        s.upvec_x = -6; s.upvec_y = 0; s.upvec_z = 10;
      end
      2: begin
        s.upvec_x = 0; s.upvec_y = 0; s.upvec_z = 0;
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic lvm_tb_pkg::vec_set_t mk(longint ex, longint ey, longint ez, longint tx,
                                              longint ty, longint tz, longint ux, longint uy,
                                              longint uz);
    lvm_tb_pkg::vec_set_t s;
    s = '{lvm_pkg::coord_t'(ex), lvm_pkg::coord_t'(ey), lvm_pkg::coord_t'(ez),
          lvm_pkg::coord_t'(tx), lvm_pkg::coord_t'(ty), lvm_pkg::coord_t'(tz),
          lvm_pkg::coord_t'(ux), lvm_pkg::coord_t'(uy), lvm_pkg::coord_t'(uz)};
    return s;
  endfunction

  // Drives one vector set and waits for its transaction.
  task automatic send_set(lvm_tb_pkg::vec_set_t s);
    in_ch.valid <= 1'b1;
    in_ch.eye_x <= s.eye_x; in_ch.eye_y <= s.eye_y; in_ch.eye_z <= s.eye_z;
    in_ch.target_x <= s.target_x; in_ch.target_y <= s.target_y;
    in_ch.target_z <= s.target_z;
    in_ch.upvec_x <= s.upvec_x; in_ch.upvec_y <= s.upvec_y; in_ch.upvec_z <= s.upvec_z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_vec_set(s);
  endtask

  // Sends a set, then idles for a random gap.
  task automatic send_with_gap(lvm_tb_pkg::vec_set_t s);
    int g;
    send_set(s);
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  localparam longint ONE = 65536;
  localparam longint MAXC = 64'sd2147483647;
  localparam longint MINC = -64'sd2147483648;

  // Stimulus.
  initial begin
    lvm_tb_pkg::vec_set_t s;
    in_ch.valid = 1'b0;
    in_ch.eye_x = '0; in_ch.eye_y = '0; in_ch.eye_z = '0;
    in_ch.target_x = '0; in_ch.target_y = '0; in_ch.target_z = '0;
    in_ch.upvec_x = '0; in_ch.upvec_y = '0; in_ch.upvec_z = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: plain camera, extremes, degenerate and near-parallel cases.
    send_with_gap(mk(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0));
    send_with_gap(mk(3 * ONE, 2 * ONE, ONE, -ONE, 0, 4 * ONE, 0, 0, ONE));
    send_with_gap(mk(ONE, ONE, ONE, ONE, ONE, ONE, 0, ONE, 0));
    send_with_gap(mk(0, 0, ONE, 0, 0, 0, 0, 0, ONE));
    send_with_gap(mk(0, 0, ONE, 0, 0, 0, 0, 0, 0));
    send_with_gap(mk(0, 0, ONE, 0, 0, 0, 1, 0, MAXC));
    send_with_gap(mk(MAXC, MAXC, MAXC, MINC, MINC, MINC, 0, ONE, 0));
    send_with_gap(mk(MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MAXC, MINC));
    send_with_gap(mk(MAXC, MINC, MAXC, 0, 0, 0, MAXC, MAXC, MAXC));
    send_with_gap(mk(MINC, MAXC, 0, MAXC, MINC, 0, MINC, MINC, MINC));
    send_with_gap(mk(1, 0, 0, 0, 0, 0, 0, 1, 0));
    send_with_gap(mk(-1, -1, -1, 0, 0, 0, -1, 1, -1));
    send_with_gap(mk(MAXC, MAXC, MAXC, MAXC - 1, MAXC, MAXC, 0, 0, -1));
    send_with_gap(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    send_with_gap(mk(2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, MINC));

    // Hold off until the pipeline has drained once.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending_mats.size() != 0) @(posedge clk);

    // Random part, with a burst stretch without gaps in the middle.
    for (int n = 0; n < N_RANDOM; n++) begin
      s = rand_set();
      if (n >= 300 && n < 400) send_set(s);
      else send_with_gap(s);
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side: random stalls, collect and check each transaction.
  initial begin
    lvm_tb_pkg::view_mat_t a;
    int g;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      g = ($urandom_range(0, 4) == 0) ? 0 : gap_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        a.right_x = out_ch.right_x; a.right_y = out_ch.right_y;
        a.right_z = out_ch.right_z;
        a.trueup_x = out_ch.trueup_x; a.trueup_y = out_ch.trueup_y;
        a.trueup_z = out_ch.trueup_z;
        a.back_x = out_ch.back_x; a.back_y = out_ch.back_y; a.back_z = out_ch.back_z;
        a.shift_right = out_ch.shift_right; a.shift_up = out_ch.shift_up;
        a.shift_back = out_ch.shift_back;
        board.check_matrix(a);
      end
    end
  end

  // End of run: drain, let trailing cycles pass, then report.
  initial begin
    @(posedge clk);
    while (!stim_done || board.pending_mats.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (board.mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog.
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
